[sv/modexp_pkg.sv]
package modexp_pkg;

    // Field width of every operand and of the result
    localparam int FIELD_W = 32;

    // Default datapath width
    localparam int ME_WIDTH = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } me_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               modulus_zero;
    } me_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT
    } me_state_t;

endpackage

[sv/modular_exponentiation.sv]
// Modular exponentiation: outcome.result = base ** exponent mod modulus.
// Input channel: operands is taken at a rising edge with start high and busy
// low. For a nonzero modulus, busy stays high from the cycle after that until
// the result is out. Output channel: done is high for exactly one cycle with
// outcome valid; the receiver takes it at the end of that cycle and cannot
// stall it. Each operand is cut to WIDTH bits before use.
// A zero modulus gives modulus_zero = 1 and result 0 in the next cycle.
// Otherwise the sequencer first reduces the base, then for each of the WIDTH
// exponent bits does a square, plus a multiply when the bit is set.
// One item is in flight at a time; the next item can be taken in the
// cycle in which done is high. The reduction, every square and every
// multiply use the single shift-and-add modular multiplier, which retires
// one multiplier bit per cycle.
// Reset clears the sequencer and the done strobe; no item is lost to reset
// other than the one in flight.
module modular_exponentiation #(
    parameter int WIDTH = modexp_pkg::ME_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  modexp_pkg::me_in_t operands,
    output logic               done,
    output modexp_pkg::me_out_t outcome
);
    import modexp_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    me_state_t       state_reg, state_next;
    logic            done_reg, done_next;
    me_out_t         out_reg, out_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] mand_reg, mand_next;
    logic [WIDTH-1:0] mier_reg, mier_next;
    logic [CW-1:0]   bcnt_reg, bcnt_next;
    logic [CW-1:0]   ecnt_reg, ecnt_next;

    logic [WIDTH-1:0] base_in, exp_in, mod_in;
    logic [WIDTH+1:0] sum, diff1, diff2, m_ext, m_dbl;
    logic [WIDTH-1:0] acc_step;
    logic             fin;
    logic [WIDTH-1:0] fin_val;

    assign base_in = WIDTH'(operands.base);
    assign exp_in  = WIDTH'(operands.exponent);
    assign mod_in  = WIDTH'(operands.modulus);

    // One multiplier bit: acc = (2*acc + bit*mand) mod m, sum stays below 3m
    assign m_ext = {2'b00, m_reg};
    assign m_dbl = {1'b0, m_reg, 1'b0};
    assign sum   = {1'b0, acc_reg, 1'b0}
                 + {2'b00, (mier_reg[WIDTH-1] ? mand_reg : '0)};
    assign diff1 = sum - m_ext;
    assign diff2 = sum - m_dbl;

    always_comb
    begin
        if (sum >= m_dbl)
        begin
            acc_step = diff2[WIDTH-1:0];
        end
        else if (sum >= m_ext)
        begin
            acc_step = diff1[WIDTH-1:0];
        end
        else
        begin
            acc_step = sum[WIDTH-1:0];
        end
    end

    // Sequencer: reduce base, then square and conditional multiply per bit
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        out_next   = out_reg;
        m_next     = m_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        mand_next  = mand_reg;
        mier_next  = mier_reg;
        bcnt_next  = bcnt_reg;
        ecnt_next  = ecnt_reg;
        fin        = 1'b0;
        fin_val    = acc_step;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mod_in == '0)
                    begin
                        out_next.result       = '0;
                        out_next.modulus_zero = 1'b1;
                        done_next             = 1'b1;
                    end
                    else
                    begin
                        // base mod m computed as (1 mod m) * base mod m
                        m_next     = mod_in;
                        exp_next   = exp_in;
                        mand_next  = (mod_in == WIDTH'(1)) ? '0 : WIDTH'(1);
                        mier_next  = base_in;
                        acc_next   = '0;
                        bcnt_next  = LAST_BIT;
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                acc_next  = acc_step;
                mier_next = {mier_reg[WIDTH-2:0], 1'b0};
                bcnt_next = bcnt_reg - CW'(1);
                if (bcnt_reg == '0)
                begin
                    // mand still holds 1 mod m, the start value of r
                    base_next  = acc_step;
                    mier_next  = mand_reg;
                    acc_next   = '0;
                    bcnt_next  = LAST_BIT;
                    ecnt_next  = LAST_BIT;
                    state_next = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                acc_next  = acc_step;
                mier_next = {mier_reg[WIDTH-2:0], 1'b0};
                bcnt_next = bcnt_reg - CW'(1);
                if (bcnt_reg == '0)
                begin
                    if (exp_reg[WIDTH-1])
                    begin
                        mand_next  = base_reg;
                        mier_next  = acc_step;
                        acc_next   = '0;
                        bcnt_next  = LAST_BIT;
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end

            ST_MULT:
            begin
                acc_next  = acc_step;
                mier_next = {mier_reg[WIDTH-2:0], 1'b0};
                bcnt_next = bcnt_reg - CW'(1);
                if (bcnt_reg == '0)
                begin
                    fin = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of one exponent bit: deliver or start the next square
        if (fin)
        begin
            if (ecnt_reg == '0)
            begin
                out_next.result       = FIELD_W'(fin_val);
                out_next.modulus_zero = 1'b0;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            else
            begin
                ecnt_next  = ecnt_reg - CW'(1);
                exp_next   = {exp_reg[WIDTH-2:0], 1'b0};
                mand_next  = fin_val;
                mier_next  = fin_val;
                acc_next   = '0;
                bcnt_next  = LAST_BIT;
                state_next = ST_SQUARE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        m_reg    <= m_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        mand_reg <= mand_next;
        mier_reg <= mier_next;
        bcnt_reg <= bcnt_next;
        ecnt_reg <= ecnt_next;
    end

    // The running power lives in mand/mier between steps and leaves via fin_val
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign outcome = out_reg;

endmodule

[verif/modexp_check.sv]
// Watches both channels of the modular exponentiation block, works out the
// outcome of every item taken in and compares it with what comes out.
module modexp_check #(
    parameter int WIDTH = modexp_pkg::ME_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  modexp_pkg::me_in_t  operands,
    input  logic                done,
    input  modexp_pkg::me_out_t outcome,
    output int                  errors,
    output int                  pending
);
    import modexp_pkg::*;

    localparam logic [127:0] OPERAND_MASK = (128'd1 << WIDTH) - 128'd1;

    // Outcomes still owed by the block, oldest first
    me_out_t awaited_outcomes[$];

    // base ** exponent mod modulus by square-and-multiply on wide vectors
    function automatic me_out_t power_mod(me_in_t op);
        logic [127:0] b;
        logic [127:0] e;
        logic [127:0] m;
        logic [127:0] r;
        me_out_t      res;
        b   = {96'd0, op.base} & OPERAND_MASK;
        e   = {96'd0, op.exponent} & OPERAND_MASK;
        m   = {96'd0, op.modulus} & OPERAND_MASK;
        res = '0;
        // zero modulus: flag it, result stays 0
        if (m == 0)
        begin
            res.modulus_zero = 1'b1;
            return res;
        end
        b = b % m;
        r = 128'd1 % m;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            r = (r * r) % m;
            if (e[i])
                r = (r * b) % m;
        end
        res.result = r[FIELD_W-1:0];
        return res;
    endfunction

    // Compare each outcome, then record the item taken at this edge
    always @(posedge clk)
    begin
        me_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("outcome %h with no item outstanding", outcome);
                    errors++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (outcome.result !== want.result)
                    begin
                        $error("result: expected %h, got %h", want.result, outcome.result);
                        errors++;
                    end
                    if (outcome.modulus_zero !== want.modulus_zero)
                    begin
                        $error("modulus_zero: expected %b, got %b",
                               want.modulus_zero, outcome.modulus_zero);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                awaited_outcomes.insert(awaited_outcomes.size(), power_mod(operands));
            pending = awaited_outcomes.size();
        end
    end

endmodule

[verif/tb.sv]
module tb;
    import modexp_pkg::*;

    localparam int WIDTH        = ME_WIDTH;
    // worst case: the reduction plus a square and a multiply for every exponent bit
    localparam int LONGEST_ITEM = WIDTH * (1 + 2 * WIDTH);
    localparam int STALL_LIMIT  = 10 * LONGEST_ITEM;
    localparam int ITEMS_PER_PHASE = 68;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    start    = 1'b0;
    me_in_t  operands = '0;
    logic    busy;
    logic    done;
    me_out_t outcome;

    int errors;
    int pending;
    int idle_pct = 0;
    int quiet_cycles = 0;

    modular_exponentiation #(
        .WIDTH(WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .outcome (outcome)
    );

    modexp_check #(
        .WIDTH(WIDTH)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .outcome (outcome),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Cycles in which neither an item goes in nor an outcome comes out
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one item from a falling edge and hold it until taken
    task automatic send_operands(input me_in_t op);
        int  gap;
        bit  wait_idle;
        gap       = 0;
        wait_idle = 1'b0;
        if (idle_pct != 0)
        begin
            while ($urandom_range(99) < idle_pct)
                gap++;
            // half the time let the gap start once the block has gone idle
            wait_idle = ($urandom_range(1) == 1);
        end
        if (gap > 0 || wait_idle)
        begin
            start <= 1'b0;
            if (wait_idle)
            begin
                do
                    @(negedge clk);
                while (busy);
            end
            repeat (gap) @(negedge clk);
        end
        operands <= op;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic me_in_t random_operands();
        me_in_t op;
        int     kind;
        kind        = $urandom_range(99);
        op.base     = ($urandom_range(9) == 0) ? '0 : FIELD_W'($urandom);
        op.exponent = FIELD_W'($urandom);
        op.modulus  = FIELD_W'($urandom);
        if (kind < 5)
            op.modulus = '0;
        else if (kind < 10)
            op.modulus = FIELD_W'(1);
        else if (kind < 30)
            op.modulus = FIELD_W'($urandom_range(255, 2));
        if ($urandom_range(9) == 0)
            op.exponent = FIELD_W'($urandom_range(15));
        return op;
    endfunction

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items: plain case, special moduli and exponents, extremes
        send_operands(me_in_t'{base: 32'd5,        exponent: 32'd3,        modulus: 32'd13});
        send_operands(me_in_t'{base: 32'hffffffff, exponent: 32'hffffffff, modulus: 32'd0});
        send_operands(me_in_t'{base: 32'd0,        exponent: 32'd0,        modulus: 32'd0});
        send_operands(me_in_t'{base: 32'd7,        exponent: 32'd0,        modulus: 32'd1});
        send_operands(me_in_t'{base: 32'd123,      exponent: 32'd0,        modulus: 32'd5});
        send_operands(me_in_t'{base: 32'd0,        exponent: 32'd0,        modulus: 32'd7});
        send_operands(me_in_t'{base: 32'hffffffff, exponent: 32'd12345,    modulus: 32'd1});
        send_operands(me_in_t'{base: 32'd1000,     exponent: 32'd3,        modulus: 32'd7});
        send_operands(me_in_t'{base: 32'd97,       exponent: 32'd5,        modulus: 32'd97});
        send_operands(me_in_t'{base: 32'hffffffff, exponent: 32'hffffffff,
                               modulus: 32'hffffffff});
        send_operands(me_in_t'{base: 32'd0,        exponent: 32'hffffffff,
                               modulus: 32'hffffffff});
        send_operands(me_in_t'{base: 32'hffffffff, exponent: 32'd1,        modulus: 32'd2});
        send_operands(me_in_t'{base: 32'd2,        exponent: 32'd31,       modulus: 32'hffffffff});
        send_operands(me_in_t'{base: 32'hfffffffe, exponent: 32'd2,        modulus: 32'hffffffff});
        send_operands(me_in_t'{base: 32'h12345678, exponent: 32'haaaaaaaa,
                               modulus: 32'h80000000});
        send_operands(me_in_t'{base: 32'h87654321, exponent: 32'h55555555,
                               modulus: 32'hfffffffb});
        send_operands(me_in_t'{base: 32'd1,        exponent: 32'hffffffff, modulus: 32'd3});
        send_operands(me_in_t'{base: 32'hffffffff, exponent: 32'd0,        modulus: 32'hffffffff});
        send_operands(me_in_t'{base: 32'd3,        exponent: 32'h80000000,
                               modulus: 32'h7fffffff});

        // random items in four pacing phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 86;
                3:       idle_pct = 29;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_operands(random_operands());
        end
        start <= 1'b0;

        // drain, then watch for stray outcomes
        while (pending != 0)
            @(posedge clk);
        repeat (LONGEST_ITEM) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
